// ===== design/rms_pkg.sv =====
// shared constants and types for the restricted makespan search unit
`timescale 1ns / 1ps
package rms_pkg;
   localparam int MAX_MACHINES_DEF = 8;
   localparam int MAX_JOBS_DEF     = 16;
   localparam int VALUE_BITS_DEF   = 16;
   localparam int FIELD_BITS       = 16;
   localparam int SPAN_BITS        = 20;

   localparam logic ACT_MACHINE = 1'b0;
   localparam logic ACT_JOB     = 1'b1;

   typedef enum logic [10:0] {
      ST_LOAD   = 11'b00000000001,
      ST_SORTRD = 11'b00000000010,
      ST_SORTCM = 11'b00000000100,
      ST_FIT    = 11'b00000001000,
      ST_FITCHK = 11'b00000010000,
      ST_NODE   = 11'b00000100000,
      ST_SCAN   = 11'b00001000000,
      ST_TWIN   = 11'b00010000000,
      ST_BACK   = 11'b00100000000,
      ST_POP    = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;
endpackage

// ===== design/restricted_makespan_search_unit.sv =====
// top level: instance loader, job sorter and depth-first makespan search
// Load items (machines or jobs) are taken one per cycle. After the item with
// last set the block is busy (req_ready low). An insertion sort over the job
// memory then compares and shifts one entry at a time, and a fit check tests
// each job against every machine. The depth-first search enters a node, tries
// each candidate machine (with a twin check against every earlier machine) and
// backtracks one level at a time. Total search time depends on the data and
// can be very long for hard instances. The job memories are read through one
// registered port. One result (makespan, feasible, overflow) per instance is
// held in an output register. Load items of the next instance are accepted
// while that result waits; a further result waits until the held one is
// transferred.
`timescale 1ns / 1ps
module restricted_makespan_search_unit #(
   parameter int MAX_MACHINES = rms_pkg::MAX_MACHINES_DEF,
   parameter int MAX_JOBS     = rms_pkg::MAX_JOBS_DEF,
   parameter int VALUE_BITS   = rms_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [rms_pkg::FIELD_BITS-1:0] req_capacity,
   input  logic [rms_pkg::FIELD_BITS-1:0] req_job_size,
   input  logic [rms_pkg::FIELD_BITS-1:0] req_job_time,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rms_pkg::SPAN_BITS-1:0]  rsp_makespan,
   output logic                          rsp_feasible,
   output logic                          rsp_overflow
);
   import rms_pkg::*;

   localparam int MB = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int JB = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int MC = $clog2(MAX_MACHINES + 1);
   localparam int JC = $clog2(MAX_JOBS + 1);
   localparam int VB = VALUE_BITS;
   localparam int LB = VB + JC + 1;

   // memories
   logic [VB-1:0] cap_mem  [MAX_MACHINES];
   logic [VB-1:0] size_mem [MAX_JOBS];
   logic [VB-1:0] time_mem [MAX_JOBS];
   logic [LB-1:0] load_ff  [MAX_MACHINES];
   logic [MC-1:0] choice_mem [MAX_JOBS];
   logic [LB-1:0] rmax_mem   [MAX_JOBS + 1];

   state_type     state_ff;
   logic [MC-1:0] mcount_ff;
   logic [JC-1:0] jcount_ff;
   logic          ovf_ff;
   logic [LB:0]   best_ff;
   logic          fit_ff;

   // job read port (registered)
   logic [JB-1:0] jaddr;
   logic [VB-1:0] jsize_q, jtime_q;
   logic          jwr;
   logic [JB-1:0] jwaddr;
   logic [VB-1:0] jwsize, jwtime;

   // sort / search indices
   logic [JC-1:0] i_ff, j_ff, d_ff;
   logic [VB-1:0] ks_ff, kt_ff;
   logic [MC-1:0] m_ff, k_ff;
   logic [LB-1:0] rm_ff;
   logic          ok_ff;

   logic [VB-1:0] tm_ff;

   logic          rsp_valid_ff;
   logic [SPAN_BITS-1:0] rsp_span_ff;
   logic          rsp_feas_ff, rsp_ovf_ff;

   logic          req_fire;
   logic          rsp_free;
   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   logic [VB-1:0] in_cap, in_size, in_time;
   assign in_cap  = VB'(req_capacity);
   assign in_size = VB'(req_job_size);
   assign in_time = VB'(req_job_time);

   // job memory write and registered read
   always_ff @(posedge clock) begin
      if (jwr) begin
         size_mem[jwaddr] <= jwsize;
         time_mem[jwaddr] <= jwtime;
      end
      jsize_q <= size_mem[jaddr];
      jtime_q <= time_mem[jaddr];
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_action == ACT_MACHINE && mcount_ff < MC'(MAX_MACHINES))
         cap_mem[mcount_ff[MB-1:0]] <= in_cap;
   end

   logic [MB-1:0] mi, ki;
   assign mi = m_ff[MB-1:0];
   assign ki = k_ff[MB-1:0];
   logic [LB-1:0] nl, nm;
   assign nl = load_ff[mi] + LB'(tm_ff);
   assign nm = (nl > rm_ff) ? nl : rm_ff;

   // job port control
   always_comb begin
      jwr = 1'b0; jwaddr = jcount_ff[JB-1:0]; jwsize = in_size; jwtime = in_time;
      jaddr = d_ff[JB-1:0];
      unique case (state_ff)
         ST_LOAD: jwr = req_fire && req_action == ACT_JOB && jcount_ff < JC'(MAX_JOBS);
         // read key at i, or neighbor at j-1; place key at slot 0
         ST_SORTRD: begin
            jaddr = ok_ff ? JB'(j_ff - 1'b1) : i_ff[JB-1:0];
            if (ok_ff && j_ff == '0) begin
               jwr = 1'b1; jwaddr = '0; jwsize = ks_ff; jwtime = kt_ff;
            end
         end
         // shift neighbor up, or place key at j
         ST_SORTCM: if (ok_ff) begin
            jwr = 1'b1; jwaddr = j_ff[JB-1:0];
            if (jtime_q < kt_ff) begin
               jwsize = jsize_q; jwtime = jtime_q;
            end else begin
               jwsize = ks_ff; jwtime = kt_ff;
            end
         end
         ST_FIT, ST_FITCHK: jaddr = i_ff[JB-1:0];
         ST_BACK: jaddr = JB'(d_ff - 1'b1);
         default: ;
      endcase
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         mcount_ff <= '0; jcount_ff <= '0; ovf_ff <= 1'b0; ok_ff <= 1'b0;
         best_ff <= '1; rsp_valid_ff <= 1'b0;
         for (int x = 0; x < MAX_MACHINES; x++) load_ff[x] <= '0;
      end else begin
         // output register: a new result may follow a transfer in the same cycle
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_LOAD: if (req_fire) begin
               if (req_action == ACT_MACHINE) begin
                  if (mcount_ff < MC'(MAX_MACHINES)) mcount_ff <= mcount_ff + 1'b1;
                  else ovf_ff <= 1'b1;
               end else begin
                  if (jcount_ff < JC'(MAX_JOBS)) jcount_ff <= jcount_ff + 1'b1;
                  else ovf_ff <= 1'b1;
               end
               if (req_last) begin
                  i_ff <= JC'(1); ok_ff <= 1'b0;
                  state_ff <= ST_SORTRD;
               end
            end
            // insertion sort, longest time first, stable
            ST_SORTRD: begin
               if (!ok_ff) begin
                  if (i_ff >= jcount_ff) begin
                     i_ff <= '0; state_ff <= ST_FIT;
                  end else state_ff <= ST_SORTCM;
               end else if (j_ff == '0) begin
                  ok_ff <= 1'b0; i_ff <= i_ff + 1'b1;
               end else state_ff <= ST_SORTCM;
            end
            ST_SORTCM: begin
               state_ff <= ST_SORTRD;
               if (!ok_ff) begin
                  ks_ff <= jsize_q; kt_ff <= jtime_q; ok_ff <= 1'b1; j_ff <= i_ff;
               end else if (jtime_q < kt_ff) begin
                  j_ff <= j_ff - 1'b1;
               end else begin
                  ok_ff <= 1'b0; i_ff <= i_ff + 1'b1;
               end
            end
            // fit check over jobs
            ST_FIT: begin
               if (i_ff >= jcount_ff) begin
                  fit_ff <= 1'b1; d_ff <= '0; m_ff <= '0; rm_ff <= '0;
                  rmax_mem[0] <= '0; choice_mem[0] <= '0;
                  state_ff <= (jcount_ff == '0) ? ST_DONE : ST_NODE;
                  if (jcount_ff == '0) best_ff <= '0;
               end else begin
                  k_ff <= '0; ok_ff <= 1'b0; state_ff <= ST_FITCHK;
               end
            end
            ST_FITCHK: begin
               if (k_ff < mcount_ff) begin
                  if (jsize_q <= cap_mem[ki]) ok_ff <= 1'b1;
                  k_ff <= k_ff + 1'b1;
               end else if (ok_ff) begin
                  ok_ff <= 1'b0; i_ff <= i_ff + 1'b1; state_ff <= ST_FIT;
               end else begin
                  fit_ff <= 1'b0; state_ff <= ST_DONE;
               end
            end
            // search node entry: job d fetched next cycle
            ST_NODE: begin
               if (d_ff >= jcount_ff) begin
                  if ({1'b0, rm_ff} < best_ff) best_ff <= {1'b0, rm_ff};
                  state_ff <= ST_BACK;
               end else begin
                  m_ff <= choice_mem[d_ff[JB-1:0]];
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               tm_ff <= jtime_q;
               if (m_ff >= mcount_ff) state_ff <= ST_BACK;
               else if (jsize_q > cap_mem[mi]) m_ff <= m_ff + 1'b1;
               else begin
                  k_ff <= '0; state_ff <= ST_TWIN;
               end
            end
            // skip twins, prune, else descend
            ST_TWIN: begin
               if (k_ff < m_ff) begin
                  if (cap_mem[ki] == cap_mem[mi] && load_ff[ki] == load_ff[mi]) begin
                     m_ff <= m_ff + 1'b1; state_ff <= ST_SCAN;
                  end else k_ff <= k_ff + 1'b1;
               end else if ({1'b0, nm} >= best_ff) begin
                  m_ff <= m_ff + 1'b1; state_ff <= ST_SCAN;
               end else begin
                  choice_mem[d_ff[JB-1:0]] <= m_ff + 1'b1;
                  load_ff[mi] <= nl;
                  rmax_mem[d_ff + 1'b1] <= nm;
                  rm_ff <= nm;
                  if (d_ff + 1'b1 < JC'(MAX_JOBS))
                     choice_mem[JB'(d_ff + 1'b1)] <= '0;
                  d_ff <= d_ff + 1'b1;
                  state_ff <= ST_NODE;
               end
            end
            // backtrack: pop one level, fetch job d-1 time
            ST_BACK: begin
               if (d_ff == '0) state_ff <= ST_DONE;
               else begin
                  m_ff <= choice_mem[JB'(d_ff - 1'b1)];
                  state_ff <= ST_POP;
               end
            end
            ST_POP: begin
               load_ff[MB'(m_ff - 1'b1)] <= load_ff[MB'(m_ff - 1'b1)] - LB'(jtime_q);
               d_ff <= d_ff - 1'b1;
               rm_ff <= rmax_mem[d_ff - 1'b1];
               state_ff <= ST_NODE;
            end
            // hand the result to the output register and clear the instance
            ST_DONE: if (rsp_free) begin
               rsp_feas_ff <= fit_ff;
               rsp_ovf_ff <= ovf_ff;
               rsp_span_ff <= (fit_ff && best_ff[LB] == 1'b0) ? SPAN_BITS'(best_ff) : '0;
               mcount_ff <= '0; jcount_ff <= '0; ovf_ff <= 1'b0; best_ff <= '1;
               for (int x = 0; x < MAX_MACHINES; x++) load_ff[x] <= '0;
               state_ff <= ST_LOAD;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_makespan = rsp_span_ff;
   assign rsp_feasible = rsp_feas_ff;
   assign rsp_overflow = rsp_ovf_ff;
endmodule

// ===== design/rms_checker.sv =====
// port-level checker for the restricted makespan search unit
`timescale 1ns / 1ps
module rms_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [19:0] rsp_makespan,
   input logic rsp_feasible
);
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_ready, rsp_valid})) else $error("unknown handshake");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_makespan) &&
      $stable(rsp_feasible))
      else $error("result dropped");
   a_infeas: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_feasible |-> rsp_makespan == 20'd0)
      else $error("infeasible with nonzero makespan");
endmodule

bind restricted_makespan_search_unit rms_checker u_rms_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_makespan(rsp_makespan),
   .rsp_feasible(rsp_feasible)
);

// ===== dv/tb_restricted_makespan_search_unit.sv =====
// self-checking testbench for the restricted makespan search unit
`timescale 1ns / 1ps
module tb_restricted_makespan_search_unit;
   import rms_pkg::*;

   localparam int NUM_MACH    = MAX_MACHINES_DEF;
   localparam int NUM_JOBS    = MAX_JOBS_DEF;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int ITEM_GOAL   = 700;

   typedef struct packed {
      logic [SPAN_BITS-1:0] span;
      logic                 feas;
      logic                 ovf;
   } verdict_type;

   typedef struct {
      logic                  act;
      logic [FIELD_BITS-1:0] cap;
      logic [FIELD_BITS-1:0] size;
      logic [FIELD_BITS-1:0] dur;
      logic                  lst;
      bit                    typed;
      verdict_type           want;
   } load_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_action;
   logic [FIELD_BITS-1:0] req_capacity;
   logic [FIELD_BITS-1:0] req_job_size;
   logic [FIELD_BITS-1:0] req_job_time;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SPAN_BITS-1:0]  rsp_makespan;
   logic                  rsp_feasible;
   logic                  rsp_overflow;

   // shadow copy of the instance being loaded
   logic [FIELD_BITS-1:0] shadow_cap [NUM_MACH];
   logic [FIELD_BITS-1:0] shadow_size [NUM_JOBS];
   logic [FIELD_BITS-1:0] shadow_dur [NUM_JOBS];
   longint                shadow_load [NUM_MACH];
   int                    shadow_mcount;
   int                    shadow_jcount;
   bit                    shadow_ovf;
   longint                best_span;

   verdict_type   span_queue[$];
   load_row_type  directed_rows[$];
   int            items_accepted;
   int            spans_checked;
   int            mismatches;
   int            cycle_count;
   int            instances_sent;
   bit            quiet_phase;
   bit            rsp_taken;
   int            rsp_stall;
   bit            cur_typed;
   verdict_type   cur_want;

   restricted_makespan_search_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_capacity (req_capacity),
      .req_job_size (req_job_size),
      .req_job_time (req_job_time),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_makespan (rsp_makespan),
      .rsp_feasible (rsp_feasible),
      .rsp_overflow (rsp_overflow)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // depth-first search with bound pruning over machine choices for job d
   function automatic void place_job(int d, longint run_max);
      longint nl;
      longint nm;
      if (run_max >= best_span) return;
      if (d >= shadow_jcount) begin
         best_span = run_max;
         return;
      end
      for (int m = 0; m < shadow_mcount; m++) begin
         if (shadow_size[d] > shadow_cap[m]) continue;
         nl = shadow_load[m] + shadow_dur[d];
         nm = (nl > run_max) ? nl : run_max;
         if (nm >= best_span) continue;
         shadow_load[m] = nl;
         place_job(d + 1, nm);
         shadow_load[m] = shadow_load[m] - shadow_dur[d];
      end
   endfunction

   // store one load item; on last, order jobs, check fit and search
   function automatic void absorb_item(logic act, logic [FIELD_BITS-1:0] cap,
                                       logic [FIELD_BITS-1:0] size,
                                       logic [FIELD_BITS-1:0] dur, logic lst);
      verdict_type           v;
      bit                    fits;
      bit                    any;
      int                    j;
      logic [FIELD_BITS-1:0] ks;
      logic [FIELD_BITS-1:0] kt;
      if (act == ACT_MACHINE) begin
         if (shadow_mcount < NUM_MACH) begin
            shadow_cap[shadow_mcount] = cap;
            shadow_mcount++;
         end else shadow_ovf = 1'b1;
      end else begin
         if (shadow_jcount < NUM_JOBS) begin
            shadow_size[shadow_jcount] = size;
            shadow_dur[shadow_jcount]  = dur;
            shadow_jcount++;
         end else shadow_ovf = 1'b1;
      end
      if (!lst) return;
      // stable sort, longest processing time first
      for (int i = 1; i < shadow_jcount; i++) begin
         ks = shadow_size[i];
         kt = shadow_dur[i];
         j  = i;
         while (j > 0 && shadow_dur[j-1] < kt) begin
            shadow_size[j] = shadow_size[j-1];
            shadow_dur[j]  = shadow_dur[j-1];
            j--;
         end
         shadow_size[j] = ks;
         shadow_dur[j]  = kt;
      end
      fits = 1'b1;
      for (int i = 0; i < shadow_jcount; i++) begin
         any = 1'b0;
         for (int m = 0; m < shadow_mcount; m++)
            if (shadow_size[i] <= shadow_cap[m]) any = 1'b1;
         if (!any) fits = 1'b0;
      end
      v.span = '0;
      if (fits) begin
         for (int m = 0; m < NUM_MACH; m++) shadow_load[m] = 0;
         best_span = 64'h7fff_ffff_ffff_ffff;
         place_job(0, 0);
         v.span = best_span[SPAN_BITS-1:0];
      end
      v.feas = fits;
      v.ovf  = shadow_ovf;
      span_queue.push_back(v);
      shadow_mcount = 0;
      shadow_jcount = 0;
      shadow_ovf    = 1'b0;
   endfunction

   // input transfers feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         items_accepted++;
         absorb_item(req_action, req_capacity, req_job_size, req_job_time, req_last);
         if (req_last && cur_typed) span_queue[$] = cur_want;
      end
   end

   // result transfers compared with the oldest expectation
   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         spans_checked++;
         if (span_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: makespan=%0d feasible=%0b overflow=%0b",
                        rsp_makespan, rsp_feasible, rsp_overflow);
         end else begin
            exp_v = span_queue.pop_front();
            if (rsp_makespan !== exp_v.span || rsp_feasible !== exp_v.feas ||
                rsp_overflow !== exp_v.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch %0d: exp makespan=%0d feas=%0b ovf=%0b, got %0d %0b %0b",
                           spans_checked, exp_v.span, exp_v.feas, exp_v.ovf,
                           rsp_makespan, rsp_feasible, rsp_overflow);
            end
         end
      end
   end

   // receiver stalls, redrawn after each result transfer
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_stall = quiet_phase ? 0 : $urandom_range(0, 14);
         rsp_taken = 1'b0;
      end
      if (rsp_stall > 0) begin
         rsp_ready = 1'b0;
         rsp_stall--;
      end else rsp_ready = 1'b1;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // drive one load item; called and returns at a falling edge
   task automatic send_item(logic act, logic [FIELD_BITS-1:0] cap,
                            logic [FIELD_BITS-1:0] size, logic [FIELD_BITS-1:0] dur,
                            logic lst, bit typed, verdict_type want);
      int gap;
      int target;
      gap = quiet_phase ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action   = act;
      req_capacity = cap;
      req_job_size = size;
      req_job_time = dur;
      req_last     = lst;
      cur_typed    = typed;
      cur_want     = want;
      req_valid    = 1'b1;
      target       = items_accepted + 1;
      do @(negedge clock); while (items_accepted < target);
      if (lst) instances_sent++;
   endtask

   function automatic logic [FIELD_BITS-1:0] pick_value(bit wide);
      return wide ? FIELD_BITS'($urandom) : FIELD_BITS'($urandom_range(0, 20));
   endfunction

   // one random instance with shuffled machine and job entries
   task automatic send_instance(int nm, int nj);
      logic        kinds[$];
      int          k;
      logic        tmp;
      bit          wide;
      verdict_type none;
      none = '0;
      wide = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < nm; i++) kinds.push_back(ACT_MACHINE);
      for (int i = 0; i < nj; i++) kinds.push_back(ACT_JOB);
      for (int i = kinds.size() - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         tmp = kinds[i];
         kinds[i] = kinds[k];
         kinds[k] = tmp;
      end
      for (int i = 0; i < kinds.size(); i++)
         send_item(kinds[i], pick_value(wide), pick_value(wide),
                   ($urandom_range(0, 1) ? pick_value(1'b1) : pick_value(1'b0)),
                   (i == kinds.size() - 1), 1'b0, none);
   endtask

   function automatic load_row_type mk_row(logic act, int cap, int size, int dur, logic lst,
                                           bit typed = 1'b0, int span = 0,
                                           logic feas = 1'b0, logic ovf = 1'b0);
      load_row_type r;
      r.act       = act;
      r.cap       = FIELD_BITS'(cap);
      r.size      = FIELD_BITS'(size);
      r.dur       = FIELD_BITS'(dur);
      r.lst       = lst;
      r.typed     = typed;
      r.want.span = SPAN_BITS'(span);
      r.want.feas = feas;
      r.want.ovf  = ovf;
      return r;
   endfunction

   // stimulus
   initial begin
      int nm;
      int nj;
      int mode;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_MACHINE;
      req_capacity  = '0;
      req_job_size  = '0;
      req_job_time  = '0;
      req_last      = 1'b0;
      rsp_ready     = 1'b0;
      rsp_taken     = 1'b1;
      rsp_stall     = 0;
      cur_typed     = 1'b0;
      cur_want      = '0;
      shadow_mcount = 0;
      shadow_jcount = 0;
      shadow_ovf    = 1'b0;
      quiet_phase   = 1'b0;

      // job with no machine at all
      directed_rows.push_back(mk_row(ACT_JOB, 0, 0, 5, 1, 1, 0, 0, 0));
      // empty job list
      directed_rows.push_back(mk_row(ACT_MACHINE, 16'hffff, 0, 0, 1, 1, 0, 1, 0));
      // largest size and time on the largest machine
      directed_rows.push_back(mk_row(ACT_MACHINE, 16'hffff, 0, 0, 0));
      directed_rows.push_back(mk_row(ACT_JOB, 0, 16'hffff, 16'hffff, 1, 1, 65535, 1, 0));
      // job larger than the only machine
      directed_rows.push_back(mk_row(ACT_MACHINE, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(ACT_JOB, 0, 1, 3, 1, 1, 0, 0, 0));
      // twin machines
      directed_rows.push_back(mk_row(ACT_MACHINE, 10, 0, 0, 0));
      directed_rows.push_back(mk_row(ACT_MACHINE, 10, 0, 0, 0));
      directed_rows.push_back(mk_row(ACT_JOB, 0, 0, 5, 0));
      directed_rows.push_back(mk_row(ACT_JOB, 0, 0, 4, 0));
      directed_rows.push_back(mk_row(ACT_JOB, 0, 0, 3, 1));
      // restricted machine and equal processing times
      directed_rows.push_back(mk_row(ACT_MACHINE, 100, 0, 0, 0));
      directed_rows.push_back(mk_row(ACT_JOB, 0, 50, 10, 0));
      directed_rows.push_back(mk_row(ACT_MACHINE, 5, 0, 0, 0));
      directed_rows.push_back(mk_row(ACT_JOB, 0, 1, 10, 0));
      directed_rows.push_back(mk_row(ACT_JOB, 0, 1, 10, 1));
      // instance closed by a machine entry, zero size and time
      directed_rows.push_back(mk_row(ACT_JOB, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(ACT_MACHINE, 0, 0, 0, 1, 1, 0, 1, 0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[i])
         send_item(directed_rows[i].act, directed_rows[i].cap, directed_rows[i].size,
                   directed_rows[i].dur, directed_rows[i].lst, directed_rows[i].typed,
                   directed_rows[i].want);

      // random instances, small ones mostly so the search stays short
      while (items_accepted < ITEM_GOAL) begin
         quiet_phase = ((items_accepted / 60) % 4 == 3);
         mode = $urandom_range(0, 19);
         case (mode)
            0: begin
               nm = $urandom_range(9, 10);
               nj = $urandom_range(0, 2);
            end
            1: begin
               nm = 1;
               nj = $urandom_range(17, 19);
            end
            2: begin
               nm = 0;
               nj = $urandom_range(1, 2);
            end
            3: begin
               nm = 8;
               nj = $urandom_range(1, 3);
            end
            4: begin
               nm = 2;
               nj = $urandom_range(6, 9);
            end
            default: begin
               nm = $urandom_range(1, 3);
               nj = $urandom_range(0, 5);
            end
         endcase
         send_instance(nm, nj);
      end
      req_valid = 1'b0;

      // drain outstanding results
      while (span_queue.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("%0d load items in %0d instances, %0d results checked, %0d mismatches",
               items_accepted, instances_sent, spans_checked, mismatches);
      if (mismatches == 0 && span_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
design/rms_pkg.sv
design/restricted_makespan_search_unit.sv
design/rms_checker.sv
dv/tb_restricted_makespan_search_unit.sv
